/* hw/rtl/spf_pkg.sv */
package spf_pkg;

  localparam logic [31:0] LOOPBACK_ADDR = 32'h0100_007F;
  localparam logic [8:0]  SCORE_MAX     = 9'd511;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] PROTO_RAW  = 8'd255;
  localparam logic [7:0] ICMP_CODE_UNREACH = 8'd3;

  localparam logic [2:0] CFG_BLOCK_THRESHOLD = 3'd0;
  localparam logic [2:0] CFG_SCORE_CAP       = 3'd1;
  localparam logic [2:0] CFG_SYN_PENALTY     = 3'd2;
  localparam logic [2:0] CFG_FLAG_PENALTY    = 3'd3;
  localparam logic [2:0] CFG_UNREACH_PENALTY = 3'd4;

  localparam logic [1:0] CONN_NONE = 2'd0;
  localparam logic [1:0] CONN_FIND = 2'd1;
  localparam logic [1:0] CONN_ADD  = 2'd2;
  localparam logic [1:0] CONN_DEL  = 2'd3;

  typedef struct packed {
    logic [8:0] block_threshold;
    logic [7:0] score_cap;
    logic [5:0] syn_penalty;
    logic [5:0] flag_penalty;
    logic [5:0] unreach_penalty;
  } cfg_t;

  // one classified packet as handed from front to back
  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [7:0]  proto;
    logic        bl_check;
    logic [1:0]  conn_op;
    logic        pen1_en;
    logic [5:0]  pen1;
    logic        pen2_en;
    logic [5:0]  pen2;
    logic        base_drop;
  } op_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [7:0]  proto;
  } conn_ent_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [8:0]  score;
  } bl_ent_t;

  typedef struct packed {
    logic init_done;
    logic busy;
  } back_stat_t;

  function automatic logic [8:0] score_bump(logic [8:0] s, logic exists,
                                            logic [7:0] cap, logic [5:0] p);
    logic [9:0] sum;
    logic [8:0] res;
    sum = {1'b0, s} + {4'd0, p};
    if (!exists) begin
      res = {3'd0, p};
    end else if (s >= {1'b0, cap}) begin
      res = s;
    end else if (sum > {1'b0, SCORE_MAX}) begin
      res = SCORE_MAX;
    end else begin
      res = sum[8:0];
    end
    return res;
  endfunction

endpackage

/* hw/rtl/spf_front.sv */
module spf_front (
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_action,
  input  logic             in_is_ipv4,
  input  logic [7:0]       in_protocol,
  input  logic [31:0]      in_src_addr,
  input  logic [31:0]      in_dst_addr,
  input  logic [15:0]      in_src_port,
  input  logic [15:0]      in_dst_port,
  input  logic             in_flag_syn,
  input  logic             in_flag_ack,
  input  logic             in_flag_rst,
  input  logic             in_flag_fin,
  input  logic [7:0]       in_icmp_code,
  input  spf_pkg::cfg_t    cfg,
  input  logic             init_done,
  input  logic             q_full,
  output logic             q_push,
  output spf_pkg::op_t     q_data
);

  assign in_ready = init_done && !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_data = '0;
    if (!in_action) begin
      q_data.addr = in_src_addr;
      q_data.port = in_src_port;
      if (in_is_ipv4) begin
        priority if (in_protocol == spf_pkg::PROTO_TCP) begin
          q_data.proto    = spf_pkg::PROTO_TCP;
          q_data.bl_check = 1'b1;
          q_data.conn_op  = spf_pkg::CONN_FIND;
          q_data.pen1_en  = in_flag_syn;
          q_data.pen1     = cfg.syn_penalty;
          q_data.pen2_en  = in_flag_ack || in_flag_rst || in_flag_fin;
          q_data.pen2     = cfg.flag_penalty;
        end else if (in_protocol == spf_pkg::PROTO_UDP) begin
          q_data.proto    = spf_pkg::PROTO_UDP;
          q_data.bl_check = 1'b1;
          q_data.conn_op  = spf_pkg::CONN_ADD;
        end else if (in_protocol == spf_pkg::PROTO_ICMP ||
                     in_protocol == spf_pkg::PROTO_RAW) begin
          q_data.base_drop = 1'b1;
        end else begin
          q_data.base_drop = 1'b0;
        end
      end
    end else begin
      q_data.addr = in_dst_addr;
      q_data.port = in_dst_port;
      priority if (in_protocol == spf_pkg::PROTO_TCP) begin
        q_data.proto    = spf_pkg::PROTO_TCP;
        q_data.bl_check = 1'b1;
        if (in_flag_syn && !in_flag_ack) begin
          q_data.conn_op = spf_pkg::CONN_ADD;
        end else if (in_flag_fin) begin
          q_data.conn_op = spf_pkg::CONN_DEL;
        end
      end else if (in_protocol == spf_pkg::PROTO_UDP) begin
        q_data.bl_check = 1'b1;
      end else if (in_protocol == spf_pkg::PROTO_ICMP &&
                   in_icmp_code == spf_pkg::ICMP_CODE_UNREACH) begin
        q_data.pen1_en   = 1'b1;
        q_data.pen1      = cfg.unreach_penalty;
        q_data.base_drop = 1'b1;
      end else begin
        q_data.base_drop = 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/spf_queue.sv */
module spf_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  spf_pkg::op_t push_data,
  output logic         full,
  input  logic         pop,
  output spf_pkg::op_t pop_data,
  output logic         empty
);

  spf_pkg::op_t slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_data;
    end
  end

endmodule

/* hw/rtl/spf_back.sv */
module spf_back #(
  parameter int CONN_ENTRIES      = 256,
  parameter int BLACKLIST_ENTRIES = 256,
  localparam int BCW = $clog2(BLACKLIST_ENTRIES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  spf_pkg::cfg_t       cfg,
  input  logic                q_empty,
  input  spf_pkg::op_t        q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_verdict,
  output spf_pkg::back_stat_t stat,
  output logic [BCW-1:0]      bl_count
);

  localparam int CIW = (CONN_ENTRIES > 1) ? $clog2(CONN_ENTRIES) : 1;
  localparam int CCW = $clog2(CONN_ENTRIES + 1);
  localparam int BIW = (BLACKLIST_ENTRIES > 1) ? $clog2(BLACKLIST_ENTRIES) : 1;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_BL    = 3'd2;
  localparam logic [2:0] S_CONN  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;

  spf_pkg::conn_ent_t conn_mem [CONN_ENTRIES];
  spf_pkg::bl_ent_t   bl_mem   [BLACKLIST_ENTRIES];
  spf_pkg::conn_ent_t conn_rd_r;
  spf_pkg::bl_ent_t   bl_rd_r;

  logic               conn_we, conn_re;
  logic [CIW-1:0]     conn_wa;
  spf_pkg::conn_ent_t conn_wd;
  logic               bl_we, bl_re;
  logic [BIW-1:0]     bl_wa;
  spf_pkg::bl_ent_t   bl_wd;

  logic [2:0]     state_r, state_nxt;
  spf_pkg::op_t   cur_r, cur_nxt;
  logic [BCW-1:0] bc_r, bc_nxt;
  logic [CCW-1:0] cc_r, cc_nxt;
  logic           brv_r, brv_nxt;
  logic           crv_r, crv_nxt;
  logic [BIW-1:0] bidx_r, bidx_nxt;
  logic [CIW-1:0] cidx_r, cidx_nxt;
  logic           bfound_r, bfound_nxt;
  logic [8:0]     bscore_r, bscore_nxt;
  logic [BIW-1:0] bhit_r, bhit_nxt;
  logic           cfound_r, cfound_nxt;
  logic [CIW-1:0] chit_r, chit_nxt;
  logic           blocked_r, blocked_nxt;
  logic [BCW-1:0] blcnt_r, blcnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           verdict_r, verdict_nxt;

  logic       bhit, chit, exempt, is_blocked, want_match, miss, pen_go, out_free;
  logic [8:0] s_a, s_b;
  logic       ex_a;

  always_ff @(posedge clk) begin
    if (conn_we) begin
      conn_mem[conn_wa] <= conn_wd;
    end
    if (conn_re) begin
      conn_rd_r <= conn_mem[cc_r[CIW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (bl_we) begin
      bl_mem[bl_wa] <= bl_wd;
    end
    if (bl_re) begin
      bl_rd_r <= bl_mem[bc_r[BIW-1:0]];
    end
  end

  always_comb begin
    exempt     = (cur_r.addr == spf_pkg::LOOPBACK_ADDR) || (cur_r.addr == 32'd0);
    bhit       = brv_r && (bl_rd_r.addr == cur_r.addr);
    is_blocked = cur_r.bl_check && !exempt && bhit &&
                 (bl_rd_r.score >= cfg.block_threshold);
    want_match = (cur_r.conn_op == spf_pkg::CONN_FIND) ||
                 (cur_r.conn_op == spf_pkg::CONN_DEL);
    // free slot has address zero; a match needs a nonzero address
    chit = crv_r && (want_match ?
           (conn_rd_r.addr != 32'd0 && conn_rd_r.addr == cur_r.addr &&
            conn_rd_r.port == cur_r.port && conn_rd_r.proto == cur_r.proto) :
           (conn_rd_r.addr == 32'd0));

    miss   = (cur_r.conn_op == spf_pkg::CONN_FIND) && !cfound_r;
    pen_go = !blocked_r && (cur_r.pen1_en || cur_r.pen2_en) &&
             ((cur_r.conn_op != spf_pkg::CONN_FIND) || !cfound_r);
    // penalties chain: the second sees the score the first left
    s_a  = cur_r.pen1_en ?
           spf_pkg::score_bump(bscore_r, bfound_r, cfg.score_cap, cur_r.pen1) : bscore_r;
    ex_a = bfound_r || cur_r.pen1_en;
    s_b  = cur_r.pen2_en ?
           spf_pkg::score_bump(s_a, ex_a, cfg.score_cap, cur_r.pen2) : s_a;
    out_free = !out_valid_r || out_ready;
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    bc_nxt        = bc_r;
    cc_nxt        = cc_r;
    brv_nxt       = brv_r;
    crv_nxt       = crv_r;
    bidx_nxt      = bidx_r;
    cidx_nxt      = cidx_r;
    bfound_nxt    = bfound_r;
    bscore_nxt    = bscore_r;
    bhit_nxt      = bhit_r;
    cfound_nxt    = cfound_r;
    chit_nxt      = chit_r;
    blocked_nxt   = blocked_r;
    blcnt_nxt     = blcnt_r;
    out_valid_nxt = (out_valid_r && out_ready) ? 1'b0 : out_valid_r;
    verdict_nxt   = verdict_r;
    conn_we = 1'b0;
    conn_wa = chit_r;
    conn_wd = '0;
    conn_re = 1'b0;
    bl_we   = 1'b0;
    bl_wa   = bhit_r;
    bl_wd   = '0;
    bl_re   = 1'b0;
    q_pop   = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        conn_we = 1'b1;
        conn_wa = cc_r[CIW-1:0];
        if (cc_r == CCW'(CONN_ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          cc_nxt = cc_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          cur_nxt     = q_data;
          bc_nxt      = '0;
          cc_nxt      = '0;
          brv_nxt     = 1'b0;
          crv_nxt     = 1'b0;
          bfound_nxt  = 1'b0;
          bscore_nxt  = '0;
          cfound_nxt  = 1'b0;
          blocked_nxt = 1'b0;
          if (q_data.bl_check || q_data.pen1_en || q_data.pen2_en) begin
            state_nxt = S_BL;
          end else if (q_data.conn_op != spf_pkg::CONN_NONE) begin
            state_nxt = S_CONN;
          end else begin
            state_nxt = S_WRITE;
          end
        end
      end
      S_BL: begin
        // read data is registered and trails the issue counter, valid in the cycle after the read is issued
        if (bhit || bc_r >= blcnt_r) begin
          brv_nxt     = 1'b0;
          bfound_nxt  = bhit;
          bscore_nxt  = bhit ? bl_rd_r.score : 9'd0;
          bhit_nxt    = bidx_r;
          blocked_nxt = is_blocked;
          if (!is_blocked && cur_r.conn_op != spf_pkg::CONN_NONE) begin
            state_nxt = S_CONN;
          end else begin
            state_nxt = S_WRITE;
          end
        end else begin
          bl_re    = 1'b1;
          brv_nxt  = 1'b1;
          bidx_nxt = bc_r[BIW-1:0];
          bc_nxt   = bc_r + 1'b1;
        end
      end
      S_CONN: begin
        if (chit || cc_r >= CCW'(CONN_ENTRIES)) begin
          crv_nxt    = 1'b0;
          cfound_nxt = chit;
          chit_nxt   = cidx_r;
          state_nxt  = S_WRITE;
        end else begin
          conn_re  = 1'b1;
          crv_nxt  = 1'b1;
          cidx_nxt = cc_r[CIW-1:0];
          cc_nxt   = cc_r + 1'b1;
        end
      end
      S_WRITE: begin
        if (out_free) begin
          if (!blocked_r && cfound_r &&
              (cur_r.conn_op == spf_pkg::CONN_ADD ||
               cur_r.conn_op == spf_pkg::CONN_DEL)) begin
            conn_we = 1'b1;
            if (cur_r.conn_op == spf_pkg::CONN_ADD) begin
              conn_wd = '{addr: cur_r.addr, port: cur_r.port, proto: cur_r.proto};
            end
          end
          if (pen_go && (bfound_r || blcnt_r < BCW'(BLACKLIST_ENTRIES))) begin
            bl_we = 1'b1;
            bl_wd = '{addr: cur_r.addr, score: s_b};
            if (!bfound_r) begin
              bl_wa     = blcnt_r[BIW-1:0];
              blcnt_nxt = blcnt_r + 1'b1;
            end
          end
          out_valid_nxt = 1'b1;
          verdict_nxt   = cur_r.base_drop || blocked_r || miss;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cc_r        <= '0;
      bc_r        <= '0;
      brv_r       <= 1'b0;
      crv_r       <= 1'b0;
      blcnt_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cc_r        <= cc_nxt;
      bc_r        <= bc_nxt;
      brv_r       <= brv_nxt;
      crv_r       <= crv_nxt;
      blcnt_r     <= blcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    bidx_r    <= bidx_nxt;
    cidx_r    <= cidx_nxt;
    bfound_r  <= bfound_nxt;
    bscore_r  <= bscore_nxt;
    bhit_r    <= bhit_nxt;
    cfound_r  <= cfound_nxt;
    chit_r    <= chit_nxt;
    blocked_r <= blocked_nxt;
    verdict_r <= verdict_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_verdict    = verdict_r;
  assign bl_count       = blcnt_r;
  assign stat.init_done = (state_r != S_CLEAR);
  assign stat.busy      = (state_r != S_IDLE) && (state_r != S_CLEAR);

endmodule

/* hw/rtl/stateful_packet_filter_blacklist.sv */
// Packet filter with a connection table and an address blacklist.
// in_* carries one summarized packet header per beat; out_verdict gives
// 0 accept or 1 drop, one beat per input beat, in order.
// cfg_* writes a register: index 0 block_threshold, 1 score_cap,
// 2 syn_penalty, 3 flag_penalty, 4 unreach_penalty; other indexes are
// ignored. cfg_ready is always high.
// A front stage decodes each header into a table command and places it in
// a two-entry queue; the back engine runs it against the tables.
// A blacklist check scans entries up to the fill count, and a connection
// search scans entries up to CONN_ENTRIES; each stops at a match and reads
// one entry at a time through the single read port of its table memory.
// One header is in the engine at a time, so the engine takes no new header
// before the last one is finished; up to two more wait in the queue.
// Reset: the connection table is swept to zero, with in_ready low until the
// sweep ends; the blacklist starts empty and registers take their defaults.
// A stalled receiver holds the verdict in the output register; the engine
// finishes the next header and then waits for the register to drain.
module stateful_packet_filter_blacklist #(
  parameter int CONN_ENTRIES      = 256,
  parameter int BLACKLIST_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic        in_is_ipv4,
  input  logic [7:0]  in_protocol,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  input  logic [15:0] in_src_port,
  input  logic [15:0] in_dst_port,
  input  logic        in_flag_syn,
  input  logic        in_flag_ack,
  input  logic        in_flag_rst,
  input  logic        in_flag_fin,
  input  logic [7:0]  in_icmp_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_verdict,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int BCW = $clog2(BLACKLIST_ENTRIES + 1);

  spf_pkg::cfg_t       cfg_r, cfg_nxt;
  spf_pkg::op_t        push_data, pop_data;
  spf_pkg::back_stat_t stat;
  logic                q_push, q_pop, q_full, q_empty;
  logic [BCW-1:0]      bl_count;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        spf_pkg::CFG_BLOCK_THRESHOLD: cfg_nxt.block_threshold = cfg_data;
        spf_pkg::CFG_SCORE_CAP:       cfg_nxt.score_cap       = cfg_data[7:0];
        spf_pkg::CFG_SYN_PENALTY:     cfg_nxt.syn_penalty     = cfg_data[5:0];
        spf_pkg::CFG_FLAG_PENALTY:    cfg_nxt.flag_penalty    = cfg_data[5:0];
        spf_pkg::CFG_UNREACH_PENALTY: cfg_nxt.unreach_penalty = cfg_data[5:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{block_threshold: 9'd100, score_cap: 8'd200, syn_penalty: 6'd30,
                 flag_penalty: 6'd10, unreach_penalty: 6'd30};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  spf_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_action   (in_action),
    .in_is_ipv4  (in_is_ipv4),
    .in_protocol (in_protocol),
    .in_src_addr (in_src_addr),
    .in_dst_addr (in_dst_addr),
    .in_src_port (in_src_port),
    .in_dst_port (in_dst_port),
    .in_flag_syn (in_flag_syn),
    .in_flag_ack (in_flag_ack),
    .in_flag_rst (in_flag_rst),
    .in_flag_fin (in_flag_fin),
    .in_icmp_code(in_icmp_code),
    .cfg         (cfg_r),
    .init_done   (stat.init_done),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (push_data)
  );

  spf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (pop_data),
    .empty    (q_empty)
  );

  spf_back #(
    .CONN_ENTRIES     (CONN_ENTRIES),
    .BLACKLIST_ENTRIES(BLACKLIST_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_data     (pop_data),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_verdict(out_verdict),
    .stat       (stat),
    .bl_count   (bl_count)
  );

  a_bl_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bl_count <= BCW'(BLACKLIST_ENTRIES))
    else $error("blacklist fill count beyond table size");

  a_bl_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (bl_count == $past(bl_count) ||
                      bl_count == $past(bl_count) + 1'b1))
    else $error("blacklist fill count moved by more than one append");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.init_done |-> (!out_valid && !in_ready && q_empty))
    else $error("traffic during connection table sweep");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!q_empty && !stat.busy))
    else $error("queue popped while engine busy or queue empty");

endmodule
